>>> design/url_query_param_parser_defines.svh
// Assertion macros for the URL query parser.
// Used by url_query_param_parser.sv; expects clk and rst_n in scope.
`ifndef URL_QUERY_PARAM_PARSER_DEFINES_SVH
`define URL_QUERY_PARAM_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define UQPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define UQPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/uqpp_pkg.sv
// Types, character codes and helpers for the URL query parser.
// No dependencies; used by the channel interface and the top level.
`timescale 1ns / 1ps

package uqpp_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_PAIR = 3'd0,
        PH_KEY  = 3'd1,
        PH_VAL  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    // Result status codes
    localparam logic [2:0] ST_RUN         = 3'd0;
    localparam logic [2:0] ST_OK          = 3'd1;
    localparam logic [2:0] ST_TERM_IN_KEY = 3'd2;
    localparam logic [2:0] ST_NO_EQUALS   = 3'd3;
    localparam logic [2:0] ST_BAD_HEX     = 3'd4;
    localparam logic [2:0] ST_TRUNCATED   = 3'd5;

    // Character codes
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    // Marker for a byte that is not a hex digit
    localparam logic [4:0] HEX_NONE = 5'd16;

    // Input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       last_byte;
    } query_t;

    // Output beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       in_value;
        logic       key_done;
        logic       pair_done;
        logic [2:0] status;
    } pair_t;

    // Space, CR or LF end the parse
    function automatic logic is_term(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // Hex digit value, HEX_NONE when not a digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = HEX_NONE;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = 5'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = 5'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = 5'(b - 8'h37);
        end
        return v;
    endfunction

endpackage

>>> design/uqpp_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// Depends on uqpp_pkg for the default payload type.
`timescale 1ns / 1ps

interface uqpp_stream_if #(
    parameter type payload_t = uqpp_pkg::query_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/url_query_param_parser.sv
// Channel | Direction | Payload          | Beat
// query   | sink      | uqpp_pkg::query_t | one query-string byte
// pairs   | source    | uqpp_pkg::pair_t  | marked key/value byte or status
//
// Takes one byte per cycle while pairs does not stall; a beat is held in the
// input register and then leaves from the result register.
// The phase update is a single small decode between the two registers.
// Bytes that produce no result retire without using the result register.
// A stall on pairs holds the input register; reset returns to pair start.
//
// Depends on uqpp_pkg, uqpp_stream_if and url_query_param_parser_defines.svh.
`timescale 1ns / 1ps
`include "url_query_param_parser_defines.svh"

module url_query_param_parser (
    input  logic           clk,
    input  logic           rst_n,
    uqpp_stream_if.sink    query,
    uqpp_stream_if.source  pairs
);

    logic              in_valid_reg;
    uqpp_pkg::query_t  in_data_reg;
    uqpp_pkg::phase_t  phase_reg;
    uqpp_pkg::phase_t  phase_next;
    logic [3:0]        nibble_reg;
    logic [3:0]        nibble_next;
    logic              out_valid_reg;
    uqpp_pkg::pair_t   out_data_reg;

    uqpp_pkg::pair_t   res;
    logic              res_has;
    logic              advance;
    logic              accept;

    // Advance the input beat when it yields nothing or the result slot frees up
    assign advance = in_valid_reg && (!res_has || !out_valid_reg || pairs.ready);
    assign query.ready = !in_valid_reg || advance;
    assign accept = query.valid && query.ready;

    // Hold the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (query.ready)
        begin
            in_valid_reg <= query.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= query.payload;
        end
    end

    // Parser state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= uqpp_pkg::PH_PAIR;
            nibble_reg <= 4'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
        end
    end

    // Decode one byte: next phase and the result beat
    always_comb
    begin
        uqpp_pkg::phase_t ph;
        logic [3:0]       hn;
        logic [7:0]       b;
        logic             last;
        logic [4:0]       hv;

        ph   = in_data_reg.first_byte ? uqpp_pkg::PH_PAIR : phase_reg;
        hn   = in_data_reg.first_byte ? 4'd0 : nibble_reg;
        b    = in_data_reg.in_byte;
        last = in_data_reg.last_byte;
        hv   = uqpp_pkg::hex_val(b);

        res         = '0;
        phase_next  = ph;
        nibble_next = hn;

        case (ph)
            uqpp_pkg::PH_PAIR,
            uqpp_pkg::PH_KEY:
            begin
                if (ph == uqpp_pkg::PH_PAIR && uqpp_pkg::is_term(b))
                begin
                    res.status = uqpp_pkg::ST_OK;
                end
                else if (ph == uqpp_pkg::PH_PAIR && b == uqpp_pkg::CH_AMP)
                begin
                    phase_next = uqpp_pkg::PH_KEY;
                    if (last) res.status = uqpp_pkg::ST_NO_EQUALS;
                end
                else if (uqpp_pkg::is_term(b))
                begin
                    res.status = uqpp_pkg::ST_TERM_IN_KEY;
                end
                else if (b == uqpp_pkg::CH_EQUALS)
                begin
                    res.key_done = 1'b1;
                    phase_next   = uqpp_pkg::PH_VAL;
                    if (last)
                    begin
                        res.pair_done = 1'b1;
                        res.status    = uqpp_pkg::ST_OK;
                    end
                end
                else
                begin
                    res.data_byte  = b;
                    res.data_valid = 1'b1;
                    phase_next     = uqpp_pkg::PH_KEY;
                    if (last) res.status = uqpp_pkg::ST_NO_EQUALS;
                end
            end
            uqpp_pkg::PH_VAL:
            begin
                if (b == uqpp_pkg::CH_AMP)
                begin
                    res.pair_done = 1'b1;
                    phase_next    = uqpp_pkg::PH_KEY;
                    if (last) res.status = uqpp_pkg::ST_NO_EQUALS;
                end
                else if (uqpp_pkg::is_term(b))
                begin
                    res.pair_done = 1'b1;
                    res.status    = uqpp_pkg::ST_OK;
                end
                else if (b == uqpp_pkg::CH_PERCENT)
                begin
                    phase_next = uqpp_pkg::PH_HEX1;
                    if (last) res.status = uqpp_pkg::ST_TRUNCATED;
                end
                else
                begin
                    res.data_byte  = b;
                    res.data_valid = 1'b1;
                    res.in_value   = 1'b1;
                    if (last)
                    begin
                        res.pair_done = 1'b1;
                        res.status    = uqpp_pkg::ST_OK;
                    end
                end
            end
            uqpp_pkg::PH_HEX1:
            begin
                if (hv == uqpp_pkg::HEX_NONE)
                begin
                    res.status = uqpp_pkg::ST_BAD_HEX;
                end
                else
                begin
                    nibble_next = hv[3:0];
                    phase_next  = uqpp_pkg::PH_HEX2;
                    if (last) res.status = uqpp_pkg::ST_TRUNCATED;
                end
            end
            uqpp_pkg::PH_HEX2:
            begin
                if (hv == uqpp_pkg::HEX_NONE)
                begin
                    res.status = uqpp_pkg::ST_BAD_HEX;
                end
                else
                begin
                    res.data_byte  = {hn, hv[3:0]};
                    res.data_valid = 1'b1;
                    res.in_value   = 1'b1;
                    phase_next     = uqpp_pkg::PH_VAL;
                    if (last)
                    begin
                        res.pair_done = 1'b1;
                        res.status    = uqpp_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                // Parse over: drop bytes until a restart
                phase_next = uqpp_pkg::PH_DONE;
            end
        endcase

        if (res.status != uqpp_pkg::ST_RUN)
        begin
            phase_next = uqpp_pkg::PH_DONE;
        end
    end

    assign res_has = res.data_valid || res.key_done || res.pair_done ||
                     (res.status != uqpp_pkg::ST_RUN);

    // Result register: load on a producing beat, drain on handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_has)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pairs.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_has)
        begin
            out_data_reg <= res;
        end
    end

    assign pairs.valid   = out_valid_reg;
    assign pairs.payload = out_data_reg;

    // A held result always carries a marker
    `UQPP_ASSERT_NOW(a_result_marked, out_valid_reg,
        out_data_reg.data_valid || out_data_reg.key_done || out_data_reg.pair_done ||
        out_data_reg.status != uqpp_pkg::ST_RUN, "result beat without marker")

    // Value flag only rides on a data byte
    `UQPP_ASSERT_NOW(a_value_has_data, out_valid_reg && out_data_reg.in_value,
        out_data_reg.data_valid, "in_value set without data byte")

    // Any final status ends the parse
    `UQPP_ASSERT_NEXT(a_status_ends_parse, advance && res.status != uqpp_pkg::ST_RUN,
        phase_reg == uqpp_pkg::PH_DONE, "status issued but parser not done")

    // Done holds until a restart byte
    `UQPP_ASSERT_NEXT(a_done_sticky,
        phase_reg == uqpp_pkg::PH_DONE && advance && !in_data_reg.first_byte,
        phase_reg == uqpp_pkg::PH_DONE && !$past(res_has), "parser left done state")

endmodule
